@@ design/pip_pkg.sv @@
// ============================================================================
// Point-in-polygon package
// Shared widths, command codes and controller/datapath interface structs.
// ============================================================================
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 7;
    localparam int COORD_W      = 32;
    localparam int EXT_W        = COORD_W + 1;
    localparam int PROD_W       = 2 * EXT_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int SM_W         = PROD_W + 1;
    localparam int SMP_W        = 2 * SM_W;
    localparam int TOL_W        = 31;
    localparam int TOL2_W       = 2 * TOL_W;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TEST = 1'b1;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_EDGE_TOL     = 1'b1;

    // Operand pairs of the short multiplier.
    typedef enum logic [3:0] {
        MOP_WXDX, MOP_WYDY, MOP_WXWX, MOP_WYWY,
        MOP_VXDX, MOP_VYDY, MOP_VXVX, MOP_VYVY,
        MOP_DXWY, MOP_DYWX, MOP_DXDX, MOP_DYDY,
        MOP_DXVY, MOP_VXDY, MOP_TOL
    } t_mop;

    typedef enum logic [1:0] {AOP_NONE, AOP_SET, AOP_ADD, AOP_SUB} t_aop;

    typedef enum logic {SMS_CROSS, SMS_LIMIT} t_smsel;

    typedef struct packed {
        logic              wr;
        logic              clr;
        logic              ld_pt;
        logic              mul_en;
        t_mop              mop;
        t_aop              aop;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              ld_prev;
        logic              ld_cur;
        logic              shift;
        logic              diff;
        logic              sm_start;
        t_smsel            sm_sel;
        logic              c2_ld;
        logic              tol_ld;
        logic              cmp_small;
        logic              cmp_big;
        logic              toggle;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic acc_neg;
        logic acc_pos;
        logic degen;
        logic straddle;
        logic sm_done;
        logic out_free;
        logic on;
    } t_stat;

endpackage

@@ design/pip_smul.sv @@
// ============================================================================
// Serial multiplier
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ============================================================================
module pip_smul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pip_pkg::SM_W-1:0]  i_a,
    input  logic [pip_pkg::SM_W-1:0]  i_b,
    output logic                      o_done,
    output logic [pip_pkg::SMP_W-1:0] o_prod
);
    import pip_pkg::*;

    localparam int CW = $clog2(SM_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [SMP_W-1:0] r_prod;
    logic [SMP_W-1:0] r_mc;
    logic [SM_W-1:0]  r_mp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(SM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= '0;
            r_mc   <= SMP_W'(i_a);
            r_mp   <= i_b;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_prod <= r_prod + r_mc;
            end
            r_mc <= r_mc << 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_done = !r_busy;
    assign o_prod = r_prod;

endmodule

@@ design/pip_dpath.sv @@
// ============================================================================
// Point-in-polygon datapath
// Vertex store, edge differences, short multiplier, accumulator and flags.
// ============================================================================
module pip_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pip_pkg::t_cmd               i_cmd,
    input  logic [pip_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [pip_pkg::COORD_W-1:0] i_coord_x,
    input  logic [pip_pkg::COORD_W-1:0] i_coord_y,
    input  logic [pip_pkg::TOL_W-1:0]   i_tol,
    input  logic                        i_out_ready,
    output pip_pkg::t_stat              o_stat,
    output logic                        o_out_valid,
    output logic                        o_inside,
    output logic                        o_on
);
    import pip_pkg::*;

    logic [COORD_W-1:0] r_mem_x [MAX_VERTICES];
    logic [COORD_W-1:0] r_mem_y [MAX_VERTICES];
    logic [COORD_W-1:0] r_rd_x, r_rd_y;

    logic signed [COORD_W-1:0] r_tx, r_ty, r_ax, r_ay, r_bx, r_by;
    logic signed [EXT_W-1:0]   r_dx, r_dy, r_wx, r_wy, r_vx, r_vy;
    logic signed [EXT_W-1:0]   opa, opb;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, acc_mag;
    logic [TOL2_W-1:0]         r_tol2;
    logic [SMP_W-1:0]          r_c2, sm_prod;
    logic [SM_W-1:0]           sm_a, sm_b;
    logic                      sm_done;
    logic                      r_on, r_par, r_ovalid, r_oin, r_oon;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem_x[i_wr_addr] <= i_coord_x;
            r_mem_y[i_wr_addr] <= i_coord_y;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[i_cmd.rd_addr];
            r_rd_y <= r_mem_y[i_cmd.rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.mop)
            MOP_WXDX: begin opa = r_wx; opb = r_dx; end
            MOP_WYDY: begin opa = r_wy; opb = r_dy; end
            MOP_WXWX: begin opa = r_wx; opb = r_wx; end
            MOP_WYWY: begin opa = r_wy; opb = r_wy; end
            MOP_VXDX: begin opa = r_vx; opb = r_dx; end
            MOP_VYDY: begin opa = r_vy; opb = r_dy; end
            MOP_VXVX: begin opa = r_vx; opb = r_vx; end
            MOP_VYVY: begin opa = r_vy; opb = r_vy; end
            MOP_DXWY: begin opa = r_dx; opb = r_wy; end
            MOP_DYWX: begin opa = r_dy; opb = r_wx; end
            MOP_DXDX: begin opa = r_dx; opb = r_dx; end
            MOP_DYDY: begin opa = r_dy; opb = r_dy; end
            MOP_DXVY: begin opa = r_dx; opb = r_vy; end
            MOP_VXDY: begin opa = r_vx; opb = r_dy; end
            MOP_TOL:  begin
                opa = $signed({2'b00, i_tol});
                opb = $signed({2'b00, i_tol});
            end
            default:  begin opa = '0; opb = '0; end
        endcase
    end

    assign acc_mag = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign sm_a    = (i_cmd.sm_sel == SMS_LIMIT) ? SM_W'(r_tol2) : acc_mag[SM_W-1:0];
    assign sm_b    = acc_mag[SM_W-1:0];

    pip_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sm_start),
        .i_a     (sm_a),
        .i_b     (sm_b),
        .o_done  (sm_done),
        .o_prod  (sm_prod)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_pt) begin
            r_tx <= i_coord_x;
            r_ty <= i_coord_y;
        end
        if (i_cmd.ld_prev) begin
            r_ax <= r_rd_x;
            r_ay <= r_rd_y;
        end else if (i_cmd.shift) begin
            r_ax <= r_bx;
            r_ay <= r_by;
        end
        if (i_cmd.ld_cur) begin
            r_bx <= r_rd_x;
            r_by <= r_rd_y;
        end
        if (i_cmd.diff) begin
            r_dx <= EXT_W'(r_bx) - EXT_W'(r_ax);
            r_dy <= EXT_W'(r_by) - EXT_W'(r_ay);
            r_wx <= EXT_W'(r_tx) - EXT_W'(r_ax);
            r_wy <= EXT_W'(r_ty) - EXT_W'(r_ay);
            r_vx <= EXT_W'(r_tx) - EXT_W'(r_bx);
            r_vy <= EXT_W'(r_ty) - EXT_W'(r_by);
        end
        if (i_cmd.mul_en) begin
            r_prod <= opa * opb;
        end
        case (i_cmd.aop)
            AOP_SET: r_acc <= ACC_W'(r_prod);
            AOP_ADD: r_acc <= r_acc + ACC_W'(r_prod);
            AOP_SUB: r_acc <= r_acc - ACC_W'(r_prod);
            default: r_acc <= r_acc;
        endcase
        if (i_cmd.tol_ld) begin
            r_tol2 <= r_prod[TOL2_W-1:0];
        end
        if (i_cmd.c2_ld) begin
            r_c2 <= sm_prod;
        end
        if (i_cmd.clr) begin
            r_on  <= 1'b0;
            r_par <= 1'b0;
        end else begin
            if ((i_cmd.cmp_small && ($unsigned(r_acc) < ACC_W'(r_tol2)))
                    || (i_cmd.cmp_big && (r_c2 < sm_prod))) begin
                r_on <= 1'b1;
            end
            if (i_cmd.toggle && ((o_stat.acc_neg && r_dy < 0)
                    || (o_stat.acc_pos && r_dy > 0))) begin
                r_par <= !r_par;
            end
        end
        if (i_cmd.emit) begin
            r_oin <= r_on || r_par;
            r_oon <= r_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_stat.acc_neg  = r_acc[ACC_W-1];
    assign o_stat.acc_pos  = !r_acc[ACC_W-1] && (r_acc != '0);
    assign o_stat.degen    = (r_dx == '0) && (r_dy == '0);
    assign o_stat.straddle = (r_by > r_ty) != (r_ay > r_ty);
    assign o_stat.sm_done  = sm_done;
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_stat.on       = r_on;

    assign o_out_valid = r_ovalid;
    assign o_inside    = r_oin;
    assign o_on        = r_oon;

endmodule

@@ design/pip_ctrl.sv @@
// ============================================================================
// Point-in-polygon controller
// Walks the edges in a boundary pass, then, unless it finds the point on an edge, a ray-crossing pass.
// ============================================================================
module pip_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load_acc,
    input  logic                       i_test_acc,
    input  logic [pip_pkg::CNT_W-1:0]  i_vcount,
    input  pip_pkg::t_stat             i_stat,
    output pip_pkg::t_cmd              o_cmd,
    output logic                       o_idle
);
    import pip_pkg::*;

    typedef enum logic [34:0] {
        S_IDLE = (35'd1 << 0),  S_TOL1 = (35'd1 << 1),  S_TOL2 = (35'd1 << 2),
        S_RDP  = (35'd1 << 3),  S_LDP  = (35'd1 << 4),  S_RDC  = (35'd1 << 5),
        S_LDC  = (35'd1 << 6),  S_DIFF = (35'd1 << 7),  S_B1   = (35'd1 << 8),
        S_B2   = (35'd1 << 9),  S_B3   = (35'd1 << 10), S_B4   = (35'd1 << 11),
        S_B5   = (35'd1 << 12), S_B6   = (35'd1 << 13), S_B7   = (35'd1 << 14),
        S_B8   = (35'd1 << 15), S_N1   = (35'd1 << 16), S_N2   = (35'd1 << 17),
        S_N3   = (35'd1 << 18), S_CMPS = (35'd1 << 19), S_C1   = (35'd1 << 20),
        S_C2   = (35'd1 << 21), S_C3   = (35'd1 << 22), S_C4   = (35'd1 << 23),
        S_C5   = (35'd1 << 24), S_C6   = (35'd1 << 25), S_C7   = (35'd1 << 26),
        S_C8   = (35'd1 << 27), S_C9   = (35'd1 << 28), S_X1   = (35'd1 << 29),
        S_X2   = (35'd1 << 30), S_X3   = (35'd1 << 31), S_X4   = (35'd1 << 32),
        S_BEND = (35'd1 << 33), S_OUT  = (35'd1 << 34)
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx, r_last, n_last;
    logic              r_pass, n_pass, r_endb, n_endb;
    logic [CNT_W-1:0]  nsat;

    assign nsat = (i_vcount > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : i_vcount;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_last  = r_last;
        n_pass  = r_pass;
        n_endb  = r_endb;
        o_cmd   = '0;
        o_cmd.rd_addr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr = i_load_acc;
                if (i_test_acc) begin
                    o_cmd.clr   = 1'b1;
                    o_cmd.ld_pt = 1'b1;
                    n_last      = ADDR_W'(nsat - 1'b1);
                    n_state     = (nsat == '0) ? S_OUT : S_TOL1;
                end
            end
            S_TOL1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_TOL;
                n_state      = S_TOL2;
            end
            S_TOL2: begin
                o_cmd.tol_ld = 1'b1;
                n_pass       = 1'b0;
                n_state      = S_RDP;
            end
            S_RDP: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_last;
                n_idx         = '0;
                n_state       = S_LDP;
            end
            S_LDP: begin
                o_cmd.ld_prev = 1'b1;
                n_state       = S_RDC;
            end
            S_RDC: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LDC;
            end
            S_LDC: begin
                o_cmd.ld_cur = 1'b1;
                n_state      = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                if (r_pass) begin
                    n_state = i_stat.straddle ? S_X1 : S_BEND;
                end else begin
                    n_state = S_B1;
                end
            end
            S_B1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_WXDX;
                n_state      = S_B2;
            end
            S_B2: begin
                o_cmd.aop    = AOP_SET;
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_WYDY;
                n_state      = S_B3;
            end
            S_B3: begin
                o_cmd.aop = AOP_ADD;
                n_state   = S_B4;
            end
            S_B4: begin
                if (i_stat.acc_neg || i_stat.degen) begin
                    n_endb  = 1'b0;
                    n_state = S_N1;
                end else begin
                    n_state = S_B5;
                end
            end
            S_B5: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_VXDX;
                n_state      = S_B6;
            end
            S_B6: begin
                o_cmd.aop    = AOP_SET;
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_VYDY;
                n_state      = S_B7;
            end
            S_B7: begin
                o_cmd.aop = AOP_ADD;
                n_state   = S_B8;
            end
            S_B8: begin
                if (i_stat.acc_pos) begin
                    n_endb  = 1'b1;
                    n_state = S_N1;
                end else begin
                    n_state = S_C1;
                end
            end
            S_N1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = r_endb ? MOP_VXVX : MOP_WXWX;
                n_state      = S_N2;
            end
            S_N2: begin
                o_cmd.aop    = AOP_SET;
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = r_endb ? MOP_VYVY : MOP_WYWY;
                n_state      = S_N3;
            end
            S_N3: begin
                o_cmd.aop = AOP_ADD;
                n_state   = S_CMPS;
            end
            S_CMPS: begin
                o_cmd.cmp_small = 1'b1;
                n_state         = S_BEND;
            end
            S_C1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_DXWY;
                n_state      = S_C2;
            end
            S_C2: begin
                o_cmd.aop    = AOP_SET;
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_DYWX;
                n_state      = S_C3;
            end
            S_C3: begin
                o_cmd.aop = AOP_SUB;
                n_state   = S_C4;
            end
            S_C4: begin
                o_cmd.sm_start = 1'b1;
                o_cmd.sm_sel   = SMS_CROSS;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mop      = MOP_DXDX;
                n_state        = S_C5;
            end
            S_C5: begin
                o_cmd.aop    = AOP_SET;
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_DYDY;
                n_state      = S_C6;
            end
            S_C6: begin
                o_cmd.aop = AOP_ADD;
                n_state   = S_C7;
            end
            S_C7: begin
                if (i_stat.sm_done) begin
                    o_cmd.c2_ld = 1'b1;
                    n_state     = S_C8;
                end
            end
            S_C8: begin
                o_cmd.sm_start = 1'b1;
                o_cmd.sm_sel   = SMS_LIMIT;
                n_state        = S_C9;
            end
            S_C9: begin
                if (i_stat.sm_done) begin
                    o_cmd.cmp_big = 1'b1;
                    n_state       = S_BEND;
                end
            end
            S_X1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_DXVY;
                n_state      = S_X2;
            end
            S_X2: begin
                o_cmd.aop    = AOP_SET;
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_VXDY;
                n_state      = S_X3;
            end
            S_X3: begin
                o_cmd.aop = AOP_SUB;
                n_state   = S_X4;
            end
            S_X4: begin
                o_cmd.toggle = 1'b1;
                n_state      = S_BEND;
            end
            S_BEND: begin
                if (!r_pass && i_stat.on) begin
                    n_state = S_OUT;
                end else if (r_idx == r_last) begin
                    if (r_pass) begin
                        n_state = S_OUT;
                    end else begin
                        n_pass  = 1'b1;
                        n_state = S_RDP;
                    end
                end else begin
                    o_cmd.shift = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    n_state     = S_RDC;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_last  <= '0;
            r_pass  <= 1'b0;
            r_endb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_last  <= n_last;
            r_pass  <= n_pass;
            r_endb  <= n_endb;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

@@ design/point_in_polygon_test.sv @@
// ============================================================================
// Point-in-polygon test
// Even-odd polygon containment with an edge tolerance, signed Q16.16.
// ============================================================================
// The block keeps up to 64 polygon vertices. A beat with tuser 0 loads one
// vertex into the slot given in tdata; it gives no result.
// A beat with tuser 1 tests a point and gives one result beat carrying the
// inside and on-boundary flags. A point closer than edge_tolerance to any
// edge, the closing edge included, is on the boundary and counts as inside;
// otherwise the even-odd crossing rule of a horizontal ray decides. All
// comparisons are exact. A test runs a boundary pass over the edges, which
// stops at the first edge found within tolerance, and then, only if none
// was, a crossing pass. In the boundary pass the point is checked against
// an edge's first endpoint when it lies behind it, its second endpoint when
// it lies beyond it, and else against the segment, where two products of
// 67-bit operands go through the serial shift-and-add multiplier. In the
// crossing pass only an edge that spans the point's y gets a cross product.
// Each pass starts with vertex store reads; a test first squares the
// tolerance and ends by handing over the result. A new beat is taken once
// the previous test has placed its result in the output register, even if
// that result has not yet been taken. vertex_count values above 64 act as
// 64, and a count of zero answers both flags 0.
// ============================================================================
module point_in_polygon_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // vertex_index[5:0], coord_x[37:6], coord_y[69:38]
    input  logic        i_s_tuser,   // action: 0 load vertex, 1 test point
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // inside_res[0], on_boundary[1]
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pip_pkg::*;

    logic [CNT_W-1:0] r_vcount;
    logic [TOL_W-1:0] r_tol;
    logic             cfg_wr, reg_sel;
    logic             s_acc, load_acc, test_acc, idle;
    logic             out_valid, out_inside, out_on;
    t_cmd             cmd;
    t_stat            stat;

    // Register file: vertex_count at 0, edge_tolerance at 4.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_tol    <= TOL_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_VERTEX_COUNT: r_vcount <= pwdata[CNT_W-1:0];
                REG_EDGE_TOL:     r_tol    <= pwdata[TOL_W-1:0];
                default:          r_vcount <= r_vcount;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_VERTEX_COUNT: prdata = 32'(r_vcount);
            REG_EDGE_TOL:     prdata = 32'(r_tol);
            default:          prdata = '0;
        endcase
    end

    // Beats are taken only while the controller waits for work.
    assign o_s_tready = idle;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign load_acc   = s_acc && (i_s_tuser == ACTION_LOAD);
    assign test_acc   = s_acc && (i_s_tuser == ACTION_TEST);

    pip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_acc (load_acc),
        .i_test_acc (test_acc),
        .i_vcount   (r_vcount),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    pip_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_addr   (i_s_tdata[ADDR_W-1:0]),
        .i_coord_x   (i_s_tdata[37:6]),
        .i_coord_y   (i_s_tdata[69:38]),
        .i_tol       (r_tol),
        .i_out_ready (i_m_tready),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .o_inside    (out_inside),
        .o_on        (out_on)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {6'b0, out_on, out_inside};

    // A point on the boundary always reports inside.
    a_on_implies_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[1] || o_m_tdata[0]))
        else $error("on_boundary set without inside_res");

    // A test beat starts work, so no beat is taken in the next cycle.
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser) |=> !o_s_tready)
        else $error("input taken right after a test beat");

    // A load never produces a result beat of its own.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result beat after a load");

endmodule
